FILE: sv/cls_pkg.sv
// Shared types, constants and saturation helpers for the stencil step block.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package cls_pkg;

    // grid capacity and field widths
    localparam int unsigned MAX_CELLS = 1048576;
    localparam int unsigned CNT_W     = 21;
    localparam int unsigned IDX_W     = 20;
    localparam int unsigned VAL_W     = 32;
    localparam int unsigned CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCHEME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLUX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO  = 2'd2;

    // flux kinds
    localparam logic [2:0] FLUX_BURGERS = 3'd0;
    localparam logic [2:0] FLUX_CUBIC   = 3'd1;
    localparam logic [2:0] FLUX_LWR     = 3'd2;
    localparam logic [2:0] FLUX_BL      = 3'd3;
    localparam logic [2:0] FLUX_TRI     = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    // which of the up to three results of one item is being built
    typedef enum logic [1:0] {
        SLOT_A,
        SLOT_B,
        SLOT_C,
        SLOT_OVF
    } slot_t;

    // controller to datapath
    typedef struct packed {
        logic  load_in;
        logic  flux_start;
        logic  mul_en;
        logic  term_en;
        logic  fin_en;
        logic  commit;
        slot_t slot;
    } cls_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic ovf;
        logic last;
        logic k_ge1;
        logic k_ge2;
        logic flux_done;
    } cls_stat_t;

    // clamp a wide signed value to Q8.24
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic ovr32(input logic signed [63:0] x);
        return (x > 64'sd2147483647) || (x < -64'sd2147483648);
    endfunction

endpackage

`default_nettype wire

FILE: sv/cls_flux.sv
// Multi-cycle flux unit: squares, rounds, and a radix-2 divider for Buckley-Leverett.
// Depends on cls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cls_flux
    import cls_pkg::*;
(
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                start,
    input  wire signed [31:0]  u,
    input  wire        [2:0]   kind,
    output logic               done,
    output logic signed [31:0] flux
);

    typedef enum logic [2:0] {
        F_IDLE,
        F_SQ,
        F_MID,
        F_SEL,
        F_CUBE,
        F_DIV
    } phase_t;

    phase_t             phase_reg;
    logic signed [31:0] u_reg;
    logic [2:0]         kind_reg;
    logic signed [63:0] sq_reg;
    logic [63:0]        aa_reg;
    logic [39:0]        u2r_reg;
    logic [39:0]        b25_reg;
    logic [39:0]        aq_reg;
    logic signed [63:0] cube_reg;
    logic [39:0]        den_reg;
    logic [39:0]        rem_reg;
    logic [24:0]        numlo_reg;
    logic [24:0]        quo_reg;
    logic [4:0]         cnt_reg;
    logic signed [31:0] flux_reg;
    logic               done_reg;

    // combinational pieces
    logic signed [32:0] a_val;
    logic signed [65:0] aa_full;
    logic signed [63:0] sq_r24;
    logic signed [63:0] sq_r25;
    logic [63:0]        aa_r26;
    logic [39:0]        den_sum;
    logic [63:0]        num;
    logic signed [63:0] lwr;
    logic signed [31:0] u2c;
    logic signed [63:0] cube_r;
    logic signed [31:0] tri_val;
    logic [40:0]        trial;
    logic               ge;
    logic [40:0]        trial_sub;
    logic [24:0]        quo_next;

    assign a_val   = 33'sd16777216 - {u_reg[31], u_reg};
    assign aa_full = a_val * a_val;
    assign sq_r24  = sq_reg + 64'sd8388608;
    assign sq_r25  = sq_reg + 64'sd16777216;
    assign aa_r26  = aa_reg + 64'd33554432;
    assign den_sum = u2r_reg + aq_reg;
    assign num     = {u2r_reg, 24'd0} + {25'd0, den_sum[39:1]};
    assign lwr     = {{32{u_reg[31]}}, u_reg} - {24'd0, u2r_reg};
    assign u2c     = sat32({24'd0, u2r_reg});
    assign cube_r  = (cube_reg + 64'sd8388608) >>> 24;

    // trilinear: u below 0, flat on [0,1], u-1 above 1
    always_comb begin
        if (u_reg < 0) begin
            tri_val = u_reg;
        end else if (u_reg > 32'sd16777216) begin
            tri_val = u_reg - 32'sd16777216;
        end else begin
            tri_val = '0;
        end
    end

    // one quotient bit per cycle
    assign trial     = {rem_reg, numlo_reg[24]};
    assign ge        = trial >= {1'b0, den_reg};
    assign trial_sub = trial - {1'b0, den_reg};
    assign quo_next  = {quo_reg[23:0], ge};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= F_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            case (phase_reg)
                F_IDLE: begin
                    if (start) begin
                        u_reg     <= u;
                        kind_reg  <= kind;
                        phase_reg <= F_SQ;
                    end
                end
                F_SQ: begin
                    sq_reg    <= u_reg * u_reg;
                    aa_reg    <= aa_full[63:0];
                    phase_reg <= F_MID;
                end
                F_MID: begin
                    u2r_reg   <= sq_r24[63:24];
                    b25_reg   <= {1'b0, sq_r25[63:25]};
                    aq_reg    <= {2'd0, aa_r26[63:26]};
                    phase_reg <= F_SEL;
                end
                F_SEL: begin
                    case (kind_reg)
                        FLUX_BURGERS: begin
                            flux_reg  <= sat32({24'd0, b25_reg});
                            done_reg  <= 1'b1;
                            phase_reg <= F_IDLE;
                        end
                        FLUX_CUBIC: begin
                            cube_reg  <= u2c * u_reg;
                            phase_reg <= F_CUBE;
                        end
                        FLUX_LWR: begin
                            flux_reg  <= sat32(lwr);
                            done_reg  <= 1'b1;
                            phase_reg <= F_IDLE;
                        end
                        FLUX_BL: begin
                            if (den_sum == '0) begin
                                flux_reg  <= '0;
                                done_reg  <= 1'b1;
                                phase_reg <= F_IDLE;
                            end else begin
                                den_reg   <= den_sum;
                                rem_reg   <= {1'b0, num[63:25]};
                                numlo_reg <= num[24:0];
                                quo_reg   <= '0;
                                cnt_reg   <= '0;
                                phase_reg <= F_DIV;
                            end
                        end
                        FLUX_TRI: begin
                            flux_reg  <= tri_val;
                            done_reg  <= 1'b1;
                            phase_reg <= F_IDLE;
                        end
                        default: begin
                            flux_reg  <= '0;
                            done_reg  <= 1'b1;
                            phase_reg <= F_IDLE;
                        end
                    endcase
                end
                F_CUBE: begin
                    flux_reg  <= sat32(cube_r);
                    done_reg  <= 1'b1;
                    phase_reg <= F_IDLE;
                end
                F_DIV: begin
                    rem_reg   <= ge ? trial_sub[39:0] : trial[39:0];
                    numlo_reg <= {numlo_reg[23:0], 1'b0};
                    quo_reg   <= quo_next;
                    cnt_reg   <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd24) begin
                        // quotient never exceeds 1.0 in Q24
                        flux_reg  <= {7'd0, quo_next};
                        done_reg  <= 1'b1;
                        phase_reg <= F_IDLE;
                    end
                end
                default: begin
                    phase_reg <= F_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign flux = flux_reg;

endmodule

`default_nettype wire

FILE: sv/cls_dp.sv
// Datapath: configuration registers, stencil history, flux unit and update arithmetic.
// Depends on cls_pkg and cls_flux.
`timescale 1ns / 1ps
`default_nettype none

module cls_dp
    import cls_pkg::*;
(
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [31:0]           cfg_data,
    input  wire signed [31:0]    s_cur_value,
    input  wire signed [31:0]    s_old_value,
    input  wire                  s_is_last,
    input  cls_cmd_t             cmd,
    output cls_stat_t            stat,
    output logic [IDX_W-1:0]     m_cell_index,
    output logic signed [31:0]   m_new_value,
    output logic                 m_last_of_run,
    output logic [1:0]           m_status
);

    // configuration
    logic        mode_reg;
    logic [2:0]  kind_reg;
    logic [31:0] ratio_reg;

    // stencil state
    logic signed [31:0] first_val_reg, second_val_reg, first_flux_reg, second_flux_reg;
    logic signed [31:0] first_old_reg, prev_old_reg;
    logic signed [31:0] hist_val_reg [2];
    logic signed [31:0] hist_flux_reg [2];
    logic [CNT_W-1:0]   count_reg;

    // current item
    logic signed [31:0] u_reg, o_reg;
    logic               last_reg;

    // update pipeline
    logic [63:0]        prod_reg;
    logic               neg_reg;
    logic signed [32:0] base_reg;
    logic signed [49:0] term_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               lastf_reg;

    logic signed [31:0] flux;
    logic               flux_done;
    logic               ovf;
    logic [IDX_W-1:0]   k_idx;

    cls_flux u_flux (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.flux_start),
        .u       (s_cur_value),
        .kind    (kind_reg),
        .done    (flux_done),
        .flux    (flux)
    );

    assign ovf   = count_reg >= CNT_W'(MAX_CELLS);
    assign k_idx = count_reg[IDX_W-1:0];

    assign stat.ovf       = ovf;
    assign stat.last      = last_reg;
    assign stat.k_ge1     = count_reg >= CNT_W'(1);
    assign stat.k_ge2     = count_reg >= CNT_W'(2);
    assign stat.flux_done = flux_done;

    // neighbor selection for the result being built
    logic signed [31:0] lv, lf, rv, rf, ov;
    logic [IDX_W-1:0]   sel_idx;
    logic               sel_last;

    always_comb begin
        lv       = u_reg;
        lf       = flux;
        rv       = u_reg;
        rf       = flux;
        ov       = o_reg;
        sel_idx  = '0;
        sel_last = 1'b0;
        case (cmd.slot)
            SLOT_A: begin
                lv      = hist_val_reg[0];
                lf      = hist_flux_reg[0];
                ov      = prev_old_reg;
                sel_idx = k_idx - IDX_W'(1);
            end
            SLOT_B: begin
                lv      = hist_val_reg[1];
                lf      = hist_flux_reg[1];
                rv      = first_val_reg;
                rf      = first_flux_reg;
                sel_idx = k_idx;
            end
            SLOT_C: begin
                // wrap to cell 0; short grids reuse the current cell
                if (count_reg >= CNT_W'(2)) begin
                    rv = second_val_reg;
                    rf = second_flux_reg;
                end
                if (count_reg != '0) begin
                    ov = first_old_reg;
                end
                sel_last = 1'b1;
            end
            default: begin
                sel_idx = '0;
            end
        endcase
    end

    logic signed [32:0] df;
    logic [32:0]        mag;
    logic signed [33:0] pair_sum;
    logic [64:0]        prod_rnd;
    logic [48:0]        t_val;
    logic signed [50:0] nv_wide;

    assign df       = {rf[31], rf} - {lf[31], lf};
    assign mag      = df[32] ? 33'(-df) : 33'(df);
    assign pair_sum = {lv[31], lv[31], lv} + {rv[31], rv[31], rv} + 34'sd1;
    assign prod_rnd = {1'b0, prod_reg} + (mode_reg ? 65'd32768 : 65'd65536);
    assign t_val    = mode_reg ? prod_rnd[64:16] : {1'b0, prod_rnd[64:17]};
    assign nv_wide  = {{18{base_reg[32]}}, base_reg} - {term_reg[49], term_reg};

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b0;
            kind_reg  <= FLUX_BURGERS;
            ratio_reg <= 32'd65536;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SCHEME: mode_reg  <= cfg_data[0];
                CFG_FLUX:   kind_reg  <= cfg_data[2:0];
                CFG_RATIO:  ratio_reg <= cfg_data;
                default:    mode_reg  <= mode_reg;
            endcase
        end
    end

    // stencil state and cell counter, updated once the item is finished
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg        <= '0;
            first_val_reg    <= '0;
            second_val_reg   <= '0;
            first_flux_reg   <= '0;
            second_flux_reg  <= '0;
            first_old_reg    <= '0;
            prev_old_reg     <= '0;
            hist_val_reg[0]  <= '0;
            hist_val_reg[1]  <= '0;
            hist_flux_reg[0] <= '0;
            hist_flux_reg[1] <= '0;
        end else if (cmd.commit) begin
            if (ovf || last_reg) begin
                if (last_reg) begin
                    count_reg <= '0;
                end
            end else begin
                if (count_reg == '0) begin
                    first_val_reg  <= u_reg;
                    first_flux_reg <= flux;
                    first_old_reg  <= o_reg;
                end else if (count_reg == CNT_W'(1)) begin
                    second_val_reg  <= u_reg;
                    second_flux_reg <= flux;
                end
                hist_val_reg[0]  <= hist_val_reg[1];
                hist_flux_reg[0] <= hist_flux_reg[1];
                hist_val_reg[1]  <= u_reg;
                hist_flux_reg[1] <= flux;
                prev_old_reg     <= o_reg;
                count_reg        <= count_reg + CNT_W'(1);
            end
        end
    end

    // item latch and update pipeline (payload, no reset)
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            u_reg    <= s_cur_value;
            o_reg    <= s_old_value;
            last_reg <= s_is_last;
        end
        if (cmd.mul_en) begin
            prod_reg  <= 64'(mag * ratio_reg);
            neg_reg   <= df[32];
            base_reg  <= mode_reg ? {ov[31], ov} : pair_sum[33:1];
            idx_reg   <= sel_idx;
            lastf_reg <= sel_last;
        end
        if (cmd.term_en) begin
            term_reg <= neg_reg ? -$signed({1'b0, t_val}) : $signed({1'b0, t_val});
        end
        if (cmd.fin_en) begin
            if (cmd.slot == SLOT_OVF) begin
                m_cell_index  <= '0;
                m_new_value   <= '0;
                m_last_of_run <= last_reg;
                m_status      <= ST_OVF;
            end else begin
                m_cell_index  <= idx_reg;
                m_new_value   <= sat32(64'(nv_wide));
                m_last_of_run <= lastf_reg;
                m_status      <= ovr32(64'(nv_wide)) ? ST_SAT : ST_OK;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/cls_ctrl.sv
// Controller: sequences flux evaluation and the up to three results of each item.
// Depends on cls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cls_ctrl
    import cls_pkg::*;
(
    input  wire       aclk,
    input  wire       aresetn,
    input  wire       s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  wire       m_ready,
    input  cls_stat_t stat,
    output cls_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FLUX,
        S_MUL,
        S_TERM,
        S_FIN,
        S_HOLD,
        S_COMMIT
    } state_t;

    state_t state_reg;
    slot_t  slot_reg;

    logic accept;
    assign accept = (state_reg == S_IDLE) && s_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            slot_reg  <= SLOT_A;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        if (stat.ovf) begin
                            slot_reg  <= SLOT_OVF;
                            state_reg <= S_FIN;
                        end else begin
                            state_reg <= S_FLUX;
                        end
                    end
                end
                S_FLUX: begin
                    // first result of the item, if any
                    if (stat.flux_done) begin
                        if (stat.k_ge2) begin
                            slot_reg  <= SLOT_A;
                            state_reg <= S_MUL;
                        end else if (stat.last && stat.k_ge1) begin
                            slot_reg  <= SLOT_B;
                            state_reg <= S_MUL;
                        end else if (stat.last) begin
                            slot_reg  <= SLOT_C;
                            state_reg <= S_MUL;
                        end else begin
                            state_reg <= S_COMMIT;
                        end
                    end
                end
                S_MUL:  state_reg <= S_TERM;
                S_TERM: state_reg <= S_FIN;
                S_FIN:  state_reg <= S_HOLD;
                S_HOLD: begin
                    if (m_ready) begin
                        case (slot_reg)
                            SLOT_A: begin
                                if (stat.last) begin
                                    slot_reg  <= SLOT_B;
                                    state_reg <= S_MUL;
                                end else begin
                                    state_reg <= S_COMMIT;
                                end
                            end
                            SLOT_B: begin
                                slot_reg  <= SLOT_C;
                                state_reg <= S_MUL;
                            end
                            default: state_reg <= S_COMMIT;
                        endcase
                    end
                end
                S_COMMIT: state_reg <= S_IDLE;
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_HOLD);

    assign cmd.load_in    = accept;
    assign cmd.flux_start = accept && !stat.ovf;
    assign cmd.mul_en     = (state_reg == S_MUL);
    assign cmd.term_en    = (state_reg == S_TERM);
    assign cmd.fin_en     = (state_reg == S_FIN);
    assign cmd.commit     = (state_reg == S_COMMIT);
    assign cmd.slot       = slot_reg;

endmodule

`default_nettype wire

FILE: sv/conservation_law_stencil_step_unit.sv
// Stencil step unit top level: one item at a time, up to three results per item.
// Flux comes first; cubic adds a cube step, Buckley-Leverett a divide (skipped if its
// denominator is zero). Each result then passes multiply, term and finish steps and is
// held until the output takes it; the next item is accepted only after the commit.
// Synchronous active-low reset clears counters, history and config to defaults.
`timescale 1ns / 1ps
`default_nettype none

module conservation_law_stencil_step_unit
    import cls_pkg::*;
(
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [31:0]           cfg_data,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire signed [31:0]    s_cur_value,
    input  wire signed [31:0]    s_old_value,
    input  wire                  s_is_last,
    output logic                 m_valid,
    input  wire                  m_ready,
    output logic [IDX_W-1:0]     m_cell_index,
    output logic signed [31:0]   m_new_value,
    output logic                 m_last_of_run,
    output logic [1:0]           m_status
);

    cls_cmd_t  cmd;
    cls_stat_t stat;

    cls_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    cls_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_cur_value   (s_cur_value),
        .s_old_value   (s_old_value),
        .s_is_last     (s_is_last),
        .cmd           (cmd),
        .stat          (stat),
        .m_cell_index  (m_cell_index),
        .m_new_value   (m_new_value),
        .m_last_of_run (m_last_of_run),
        .m_status      (m_status)
    );

endmodule

`default_nettype wire
